// ===== design/bse_pkg.sv =====
// Shared constants, codes and types of the bounded stack engine.
package bse_pkg;

   // Storage size and derived widths
   localparam int DEPTH  = 256;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W  = $clog2(DEPTH + 1);

   // Fixed field widths
   localparam int OP_W   = 3;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 9;
   localparam int CAP_W  = 9;
   localparam int OCC_W  = 9;
   localparam int STAT_W = 2;

   // Width that holds any level, count or capacity plus one carry bit
   localparam int CMP_W = ((LVL_W > CNT_W) ? LVL_W : CNT_W) + 1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PEEK  = 3'd2,
      OP_DUP   = 3'd3,
      OP_SWAP  = 3'd4,
      OP_REV3  = 3'd5,
      OP_PUSHN = 3'd6,
      OP_NOP   = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_XCHG,
      S_WBACK,
      S_FILL
   } state_type;

   // Memory access issued by the sequencer
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // Completed request handed to the result register
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] top;
      logic [LVL_W-1:0]  fill;
      stat_type          status;
   } post_type;

endpackage

// ===== design/bse_channels.sv =====
// Handshake channel interfaces: request, response and capacity register write.
interface bse_req_if;
   logic                                valid;
   logic                                ready;
   logic        [bse_pkg::OP_W-1:0]     op;
   logic signed [bse_pkg::WORD_W-1:0]   value;
   logic        [bse_pkg::CNT_W-1:0]    count;

   modport source (output valid, op, value, count, input ready);
   modport sink   (input valid, op, value, count, output ready);
endinterface

interface bse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bse_pkg::WORD_W-1:0]   top_value;
   logic                                top_valid;
   logic                                is_empty;
   logic                                is_full;
   logic        [bse_pkg::OCC_W-1:0]    occupancy;
   logic        [bse_pkg::STAT_W-1:0]   status;

   modport source (output valid, top_value, top_valid, is_empty, is_full, occupancy, status,
                   input ready);
   modport sink   (input valid, top_value, top_valid, is_empty, is_full, occupancy, status,
                   output ready);
endinterface

interface bse_csr_if;
   logic                                valid;
   logic                                ready;
   logic        [bse_pkg::CAP_W-1:0]    capacity_in_use;

   modport source (output valid, capacity_in_use, input ready);
   modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== design/bse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bse_seq.sv =====
// Stack sequencer: fill level, cached top word and the memory access steps.
module bse_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  logic [bse_pkg::OP_W-1:0]      req_op,
   input  logic [bse_pkg::WORD_W-1:0]    req_value,
   input  logic [bse_pkg::CNT_W-1:0]     req_count,
   input  logic [bse_pkg::LVL_W-1:0]     cap,
   input  logic [bse_pkg::WORD_W-1:0]    rd_data,
   output bse_pkg::mem_req_type          mem,
   output bse_pkg::post_type             post,
   output logic                          idle
);
   import bse_pkg::*;

   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   fill_ff, fill_in;
   logic [WORD_W-1:0]  top_ff, top_in;
   logic [WORD_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   op_type             op;
   stat_type           stat;
   logic [CMP_W-1:0]   nx, capx, cntx;
   logic               go_load, go_xchg, go_fill;

   assign op   = op_type'(req_op);
   assign nx   = CMP_W'(fill_ff);
   assign capx = CMP_W'(cap);
   assign cntx = CMP_W'(req_count);
   assign idle = (state_ff == S_IDLE);

   // Decode request against the current level and capacity
   always_comb begin
      stat    = STAT_OK;
      go_load = 1'b0;
      go_xchg = 1'b0;
      go_fill = 1'b0;
      unique case (op)
         OP_PUSH: begin
            if (nx >= capx) stat = STAT_OVERFLOW;
         end
         OP_POP: begin
            if (fill_ff == '0) stat = STAT_UNDERFLOW;
            else go_load = (fill_ff >= LVL_W'(2));
         end
         OP_PEEK: begin
            if (fill_ff == '0) stat = STAT_UNDERFLOW;
         end
         OP_DUP: begin
            if (fill_ff == '0) stat = STAT_UNDERFLOW;
            else if (nx >= capx) stat = STAT_OVERFLOW;
         end
         OP_SWAP: begin
            if (fill_ff < LVL_W'(2)) stat = STAT_UNDERFLOW;
            else go_xchg = 1'b1;
         end
         OP_REV3: begin
            if (fill_ff < LVL_W'(3)) stat = STAT_UNDERFLOW;
            else go_xchg = 1'b1;
         end
         OP_PUSHN: begin
            if (nx + cntx > capx) stat = STAT_OVERFLOW;
            else go_fill = (req_count > CNT_W'(1));
         end
         default: begin
            stat = STAT_OK;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (go_load) state_in = S_LOAD;
               else if (go_xchg) state_in = S_XCHG;
               else if (go_fill) state_in = S_FILL;
            end
         end
         S_LOAD:  state_in = S_IDLE;
         S_XCHG:  state_in = S_WBACK;
         S_WBACK: state_in = S_IDLE;
         S_FILL: begin
            if (rem_ff == CNT_W'(1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory accesses, datapath updates and completion
   always_comb begin
      mem         = '0;
      post        = '0;
      post.status = STAT_OK;
      fill_in     = fill_ff;
      top_in      = top_ff;
      val_in      = val_ff;
      rem_in      = rem_ff;
      addr_in     = addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               post.status = stat;
               post.valid  = 1'b1;
               if (stat == STAT_OK) begin
                  case (op)
                     OP_PUSH: begin
                        mem.we    = 1'b1;
                        mem.waddr = fill_ff[ADDR_W-1:0];
                        mem.wdata = req_value;
                        fill_in   = fill_ff + LVL_W'(1);
                        top_in    = req_value;
                     end
                     OP_POP: begin
                        fill_in = fill_ff - LVL_W'(1);
                        if (go_load) begin
                           mem.re     = 1'b1;
                           mem.raddr  = ADDR_W'(fill_ff - LVL_W'(2));
                           post.valid = 1'b0;
                        end
                     end
                     OP_DUP: begin
                        mem.we    = 1'b1;
                        mem.waddr = fill_ff[ADDR_W-1:0];
                        mem.wdata = top_ff;
                        fill_in   = fill_ff + LVL_W'(1);
                     end
                     OP_SWAP: begin
                        mem.re     = 1'b1;
                        mem.raddr  = ADDR_W'(fill_ff - LVL_W'(2));
                        addr_in    = ADDR_W'(fill_ff - LVL_W'(2));
                        post.valid = 1'b0;
                     end
                     OP_REV3: begin
                        mem.re     = 1'b1;
                        mem.raddr  = ADDR_W'(fill_ff - LVL_W'(3));
                        addr_in    = ADDR_W'(fill_ff - LVL_W'(3));
                        post.valid = 1'b0;
                     end
                     OP_PUSHN: begin
                        // Write the first copy now, the rest one per cycle
                        if (req_count != '0) begin
                           mem.we     = 1'b1;
                           mem.waddr  = fill_ff[ADDR_W-1:0];
                           mem.wdata  = req_value;
                           fill_in    = fill_ff + LVL_W'(1);
                           top_in     = req_value;
                           val_in     = req_value;
                           rem_in     = req_count - CNT_W'(1);
                           post.valid = ~go_fill;
                        end
                     end
                     default: begin
                        fill_in = fill_ff;
                     end
                  endcase
               end
            end
         end
         S_LOAD: begin
            // New top arrives from memory
            top_in     = rd_data;
            post.valid = 1'b1;
         end
         S_XCHG: begin
            // Old top goes to the lower slot, lower word becomes top
            mem.we    = 1'b1;
            mem.waddr = addr_ff;
            mem.wdata = top_ff;
            top_in    = rd_data;
         end
         S_WBACK: begin
            mem.we     = 1'b1;
            mem.waddr  = ADDR_W'(fill_ff - LVL_W'(1));
            mem.wdata  = top_ff;
            post.valid = 1'b1;
         end
         S_FILL: begin
            mem.we    = 1'b1;
            mem.waddr = fill_ff[ADDR_W-1:0];
            mem.wdata = val_ff;
            fill_in   = fill_ff + LVL_W'(1);
            rem_in    = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) post.valid = 1'b1;
         end
         default: begin
            post.valid = 1'b0;
         end
      endcase
      post.fill = fill_in;
      post.top  = top_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      addr_ff <= addr_in;
   end

endmodule

// ===== design/bounded_stack_engine_core.sv =====
// Bounded LIFO stack engine top level: capacity register, entry memory, result register.
// Push, peek, dup, pop to empty and rejects complete from the request; pop passes a load state,
// swap and reverse-three the exchange and write-back states, push-n of more than one copy a fill
// state, from the registered memory read and single write port. Throughput: next request taken
// once the previous one is done and the result register is free, so simple ones run at one per cycle.
// Reset (synchronous, high) empties the stack and sets the capacity to 256; memory is not cleared.
module bounded_stack_engine_core (
   input  logic clock,
   input  logic reset,
   bse_req_if.sink   req,
   bse_rsp_if.source rsp,
   bse_csr_if.sink   csr
);
   import bse_pkg::*;

   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [LVL_W-1:0]   cap_eff;
   logic [WORD_W-1:0]  rd_data;
   mem_req_type        mem;
   post_type           post;
   logic               idle;
   logic               out_free;
   logic               req_fire;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_top_ff, rsp_top_in;
   logic               rsp_tv_ff, rsp_tv_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   // Capacity register, limited to the memory depth
   assign csr.ready = 1'b1;
   assign cap_in    = (csr.valid) ? csr.capacity_in_use : cap_ff;
   assign cap_eff   = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? LVL_W'(DEPTH) : LVL_W'(cap_ff);

   // Request handshake
   assign out_free  = ~rsp_valid_ff | rsp.ready;
   assign req.ready = idle & out_free;
   assign req_fire  = req.valid & req.ready;

   bse_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req.op),
      .req_value (req.value),
      .req_count (req.count),
      .cap       (cap_eff),
      .rd_data   (rd_data),
      .mem       (mem),
      .post      (post),
      .idle      (idle)
   );

   bse_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.we),
      .wr_addr (mem.waddr),
      .wr_data (mem.wdata),
      .rd_en   (mem.re),
      .rd_addr (mem.raddr),
      .rd_data (rd_data)
   );

   // Load result register on completion, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_top_in   = rsp_top_ff;
      rsp_tv_in    = rsp_tv_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (post.valid) begin
         rsp_valid_in = 1'b1;
         rsp_top_in   = (post.fill != '0) ? post.top : '0;
         rsp_tv_in    = (post.fill != '0);
         rsp_empty_in = (post.fill == '0);
         rsp_full_in  = (post.fill >= cap_eff);
         rsp_occ_in   = OCC_W'(post.fill);
         rsp_stat_in  = post.status;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_top_ff   <= rsp_top_in;
      rsp_tv_ff    <= rsp_tv_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.top_value = rsp_top_ff;
   assign rsp.top_valid = rsp_tv_ff;
   assign rsp.is_empty  = rsp_empty_ff;
   assign rsp.is_full   = rsp_full_ff;
   assign rsp.occupancy = rsp_occ_ff;
   assign rsp.status    = rsp_stat_ff;

endmodule
